// File: design/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants of the stripe transition blend
// Holds the configuration register indexes, the per-component output select,
// the control bundle of the component mixer and the fixed blend constants.
// ----------------------------------------------------------------------------
package stb_pkg;

  // Width of the geometry configuration registers.
  localparam int CFG_W = 13;
  // Width of one pixel component.
  localparam int PIX_W = 8;
  // Number of components in a 4:4:4 pixel.
  localparam int NUM_COMP = 3;

  // Full blend weight; both weights of a blend add up to this value.
  localparam logic [PIX_W-1:0] WEIGHT_FULL = 8'd235;
  // Width of a weighted sum w0*a + w1*b, which never exceeds 235 * 255.
  localparam int SUM_W = 16;
  // Division by 235 as a multiply by ceil(2^24 / 235) and a right shift.
  // The result is exact for every sum below 2^24 / 139.
  localparam int DIV_SHIFT = 24;
  localparam int DIV_MULT_W = 17;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 17'd71393;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ROW_WIDTH     = 3'd0,
    REG_STRIPE_PERIOD = 3'd1,
    REG_STRIPE_WIDTH  = 3'd2,
    REG_OPACITY       = 3'd3,
    REG_MODE          = 3'd4
  } stb_cfg_reg_e;

  // Blend modes.
  typedef enum logic {
    MODE_BLEND     = 1'b0,
    MODE_COPY_LUMA = 1'b1
  } stb_mode_e;

  // Source of one output component.
  typedef enum logic [1:0] {
    SEL_A   = 2'd0,
    SEL_B   = 2'd1,
    SEL_MIX = 2'd2
  } stb_sel_e;

  // Control of one component mixer: stage enables and the output select.
  typedef struct packed {
    logic     en_mul;
    logic     en_div;
    stb_sel_e sel;
  } stb_mix_ctl_t;

endpackage

// File: design/stripe_transition_blend.sv
// ----------------------------------------------------------------------------
// stripe_transition_blend: vertical stripe transition between two frames
// Pixel pairs of frame A and frame B arrive in raster order. Pixels inside
// the periodic vertical stripes are blended (mode 0) or take the luma of B
// (mode 1); every other pixel passes A through.
//
//   Channel  Direction  Carries
//   s_axis   in         tdata: A then B pixel (luma, cb, cr); tuser: frame start
//   m_axis   out        tdata: result pixel (luma, cb, cr)
//   cfg      in         write enable, register index, write data
//
// One pixel is accepted per clock while the pipeline has room. Each pixel
// passes three registered stages on its way to m_axis: a decision stage
// that reads the column counters, the weight multiply stage and the
// reciprocal divide stage. Each stage has its own valid bit and moves whenever
// the stage after it is free, so up to three results are buffered while m_axis stalls.
// Reset clears the counters, the valid bits and the registers to defaults.
// ----------------------------------------------------------------------------
module stripe_transition_blend
  import stb_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write port.
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  // Input pixel pair stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: a_luma, a_cb, a_cr, b_luma, b_cb, b_cr.
  input  logic [47:0]      s_axis_tdata,
  // Fields from bit 0: start_of_frame.
  input  logic [0:0]       s_axis_tuser,
  // Result pixel stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // Fields from bit 0: out_luma, out_cb, out_cr.
  output logic [23:0]      m_axis_tdata
);

  // Column counter width, and a width that holds every sum of geometry values.
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = ((CW > CFG_W) ? CW : CFG_W) + 2;
  localparam logic [XW-1:0] MAX_W_X = XW'(MAX_WIDTH);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] row_width_q, stripe_period_q, stripe_width_q;
  logic [PIX_W-1:0] opacity_q;
  stb_mode_e        mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q     <= CFG_W'(640);
      stripe_period_q <= CFG_W'(3);
      stripe_width_q  <= CFG_W'(10);
      opacity_q       <= PIX_W'(150);
      mode_q          <= MODE_BLEND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW_WIDTH:     row_width_q     <= cfg_wdata_i;
        REG_STRIPE_PERIOD: stripe_period_q <= cfg_wdata_i;
        REG_STRIPE_WIDTH:  stripe_width_q  <= cfg_wdata_i;
        REG_OPACITY:       opacity_q       <= cfg_wdata_i[PIX_W-1:0];
        REG_MODE:          mode_q          <= stb_mode_e'(cfg_wdata_i[0]);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Effective geometry and weights
  // --------------------------------------------------------------------------
  logic [XW-1:0]    rw_raw, rw_eff;
  logic [CFG_W-1:0] per_eff, sw_eff;
  logic [PIX_W-1:0] w0, w1;

  assign rw_raw = XW'(row_width_q);

  // A row width of zero acts as one, and widths above the maximum are clamped.
  always_comb begin
    priority if (rw_raw == '0) begin
      rw_eff = XW'(1);
    end else if (rw_raw > MAX_W_X) begin
      rw_eff = MAX_W_X;
    end else begin
      rw_eff = rw_raw;
    end
  end

  // A zero period acts as one; a stripe wider than the period gets period - 1.
  assign per_eff = (stripe_period_q == '0) ? CFG_W'(1) : stripe_period_q;
  assign sw_eff  = (per_eff < stripe_width_q) ? (per_eff - CFG_W'(1)) : stripe_width_q;

  assign w1 = (opacity_q > WEIGHT_FULL) ? WEIGHT_FULL : opacity_q;
  assign w0 = WEIGHT_FULL - w1;

  // --------------------------------------------------------------------------
  // Handshake and stage enables
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, vo_q;
  logic en_o, en2, en1;
  logic s_accept;

  assign en_o     = !vo_q || m_axis_tready;
  assign en2      = !v2_q || en_o;
  assign en1      = !v1_q || en2;
  assign s_accept = s_axis_tvalid && en1;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= s_axis_tvalid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en_o) begin
        vo_q <= v2_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Column, phase and stripe start counters
  // --------------------------------------------------------------------------
  // The phase never runs ahead of the column, and the stripe start plus the
  // phase never exceeds the column, so all three fit the column width.
  logic [CW-1:0] column_q, phase_q, stripe_start_q;
  logic [CW-1:0] column_d, phase_d, stripe_start_d;
  logic [CW-1:0] col_cur, phase_cur, ss_cur;
  logic          sof;
  logic [XW-1:0] col_inc, phase_inc;
  logic          row_wrap, period_done;
  logic          in_stripe, in_bound;

  assign sof       = s_axis_tuser[0];
  // The frame start pixel is column zero whatever the counters hold.
  assign col_cur   = sof ? '0 : column_q;
  assign phase_cur = sof ? '0 : phase_q;
  assign ss_cur    = sof ? '0 : stripe_start_q;

  assign col_inc     = XW'(col_cur) + XW'(1);
  assign phase_inc   = XW'(phase_cur) + XW'(1);
  assign row_wrap    = (col_inc >= rw_eff) || (col_inc >= MAX_W_X);
  assign period_done = phase_inc >= XW'(per_eff);

  always_comb begin
    column_d       = col_cur;
    phase_d        = phase_cur;
    stripe_start_d = ss_cur;
    if (row_wrap) begin
      column_d       = '0;
      phase_d        = '0;
      stripe_start_d = '0;
    end else begin
      column_d = col_inc[CW-1:0];
      if (period_done) begin
        phase_d        = '0;
        stripe_start_d = CW'(XW'(ss_cur) + XW'(per_eff));
      end else begin
        phase_d = phase_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q       <= '0;
      phase_q        <= '0;
      stripe_start_q <= '0;
    end else if (s_accept) begin
      column_q       <= column_d;
      phase_q        <= phase_d;
      stripe_start_q <= stripe_start_d;
    end
  end

  // --------------------------------------------------------------------------
  // Decision stage
  // --------------------------------------------------------------------------
  // Blending stops for stripes whose next period would run past the row end.
  assign in_stripe = XW'(phase_cur) < XW'(sw_eff);
  assign in_bound  = (XW'(ss_cur) + XW'(sw_eff) + XW'(per_eff)) < rw_eff;

  stb_sel_e sel_luma_d, sel_chroma_d;
  stb_sel_e sel_luma_q, sel_chroma_q;

  always_comb begin
    sel_luma_d   = SEL_A;
    sel_chroma_d = SEL_A;
    if (in_stripe) begin
      unique case (mode_q)
        MODE_BLEND: begin
          if (in_bound) begin
            sel_luma_d   = SEL_MIX;
            sel_chroma_d = SEL_MIX;
          end
        end
        MODE_COPY_LUMA: begin
          sel_luma_d = SEL_B;
        end
        default: ;
      endcase
    end
  end

  logic [NUM_COMP-1:0][PIX_W-1:0] pix_a_q, pix_b_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      pix_a_q      <= s_axis_tdata[23:0];
      pix_b_q      <= s_axis_tdata[47:24];
      sel_luma_q   <= sel_luma_d;
      sel_chroma_q <= sel_chroma_d;
    end
  end

  // --------------------------------------------------------------------------
  // Multiply and divide stages, one mixer per component
  // --------------------------------------------------------------------------
  logic [NUM_COMP-1:0][PIX_W-1:0] q_comp;

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_comp
    stb_mix_ctl_t ctl;

    assign ctl.en_mul = en2 && v1_q;
    assign ctl.en_div = en_o && v2_q;
    assign ctl.sel    = (c == 0) ? sel_luma_q : sel_chroma_q;

    stb_mix u_mix (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .a_i   (pix_a_q[c]),
      .b_i   (pix_b_q[c]),
      .w0_i  (w0),
      .w1_i  (w1),
      .q_o   (q_comp[c])
    );
  end

  assign m_axis_tdata = q_comp;

endmodule

// File: design/stb_mix.sv
// ----------------------------------------------------------------------------
// stb_mix: two-stage weighted mix of one pixel component
// The first stage forms w0*a + w1*b, the second divides by the full weight
// through a reciprocal multiply and selects between A, B and the mix.
// ----------------------------------------------------------------------------
module stb_mix
  import stb_pkg::*;
(
  input  logic             clk_i,
  input  stb_mix_ctl_t     ctl_i,
  input  logic [PIX_W-1:0] a_i,
  input  logic [PIX_W-1:0] b_i,
  input  logic [PIX_W-1:0] w0_i,
  input  logic [PIX_W-1:0] w1_i,
  output logic [PIX_W-1:0] q_o
);

  localparam int PROD_W = SUM_W + DIV_MULT_W;

  logic [SUM_W-1:0]  sum_d, sum_q;
  logic [PIX_W-1:0]  a_q, b_q;
  stb_sel_e          sel_q;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  quot;
  logic [PIX_W-1:0]  q_d, q_q;

  assign sum_d = SUM_W'(w0_i) * SUM_W'(a_i) + SUM_W'(w1_i) * SUM_W'(b_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_mul) begin
      sum_q <= sum_d;
      a_q   <= a_i;
      b_q   <= b_i;
      sel_q <= ctl_i.sel;
    end
  end

  assign prod = PROD_W'(sum_q) * PROD_W'(DIV_MULT);
  assign quot = prod[DIV_SHIFT +: PIX_W];

  always_comb begin
    unique case (sel_q)
      SEL_MIX: q_d = quot;
      SEL_B:   q_d = b_q;
      default: q_d = a_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_div) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// File: design/stb_checker.sv
// ----------------------------------------------------------------------------
// stb_checker: port-level checks of the stripe transition blend
// Watches the stream ports for stall behavior and end-to-end latency.
// ----------------------------------------------------------------------------
module stb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A waiting result stays valid and unchanged until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // The input side only blocks when every stage is full behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input blocked while the pipeline had room");

  // With the output flowing, a pixel pair of equal frames comes out unchanged
  // through the multiply and divide stages, whatever the stripe decision was.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tdata[23:0] == s_axis_tdata[47:24]))
      ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid && (m_axis_tdata == $past(s_axis_tdata[23:0], 3)))
    else $error("equal frames did not pass through in three cycles");

endmodule

bind stripe_transition_blend stb_checker u_stb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
